FILE: src/ps2mpd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared types and constants for the packet decoder modules.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

    // header byte bit positions
    localparam int HDR_LEFT    = 0;
    localparam int HDR_RIGHT   = 1;
    localparam int HDR_MIDDLE  = 2;
    localparam int HDR_ONE     = 3;
    localparam int HDR_X_SIGN  = 4;
    localparam int HDR_Y_SIGN  = 5;
    localparam int HDR_X_OVF   = 6;
    localparam int HDR_Y_OVF   = 7;

    localparam int NUM_BUTTONS = 3;
    localparam int OUT_POS_W   = 10;

    // event kinds
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_MOVE    = 2'd2;

    // button indexes
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_WHEEL   = 2'd1;

    // byte position codes
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;
    localparam logic [1:0] POS_WHEEL  = 2'd3;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_packet;

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           button;
        logic [OUT_POS_W-1:0] x;
        logic [OUT_POS_W-1:0] y;
    } t_event;

endpackage

FILE: src/ps2mpd_assembler.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler
// Collects bytes into three- or four-byte packets, resyncs on bad headers.
// ----------------------------------------------------------------------------
module ps2mpd_assembler
    import ps2mpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wheel,       // four-byte packets
    input  logic    i_byte_valid,  // byte transfer while enabled
    input  logic [7:0] i_byte,
    output logic    o_completing,  // next byte closes a packet
    output logic    o_pkt_valid,
    output t_packet o_pkt
);

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_x, n_x;
    logic [7:0] r_y, n_y;

    assign o_completing = (r_pos == POS_WHEEL) || ((r_pos == POS_Y) && !i_wheel);

    always_comb begin
        n_pos = r_pos;
        n_hdr = r_hdr;
        n_x   = r_x;
        n_y   = r_y;
        if (i_byte_valid) begin
            unique case (r_pos)
                POS_HEADER: begin
                    n_hdr = i_byte;
                    n_pos = i_byte[HDR_ONE] ? POS_X : POS_HEADER;
                end
                POS_X: begin
                    n_x   = i_byte;
                    n_pos = POS_Y;
                end
                POS_Y: begin
                    n_y   = i_byte;
                    n_pos = i_wheel ? POS_WHEEL : POS_HEADER;
                end
                default: begin
                    n_pos = POS_HEADER;  // wheel byte ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HEADER;
            r_hdr <= '0;
            r_x   <= '0;
            r_y   <= '0;
        end else begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_pkt_valid   = i_byte_valid && o_completing;
    assign o_pkt.header  = r_hdr;
    assign o_pkt.x_byte  = r_x;
    assign o_pkt.y_byte  = (r_pos == POS_Y) ? i_byte : r_y;

endmodule

FILE: src/ps2mpd_decoder.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder core
// Applies deltas to the pointer, tracks buttons, picks the event to report.
// ----------------------------------------------------------------------------
module ps2mpd_decoder
    import ps2mpd_pkg::*;
#(
    parameter int POSITION_BITS = 10
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pkt_valid,
    input  t_packet i_pkt,
    output logic    o_ev_valid,
    output t_event  o_ev
);

    localparam int DW = (POSITION_BITS > 9) ? POSITION_BITS : 9;
    localparam int OW = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

    logic [POSITION_BITS-1:0] r_pos_x, n_pos_x;
    logic [POSITION_BITS-1:0] r_pos_y, n_pos_y;
    logic [NUM_BUTTONS-1:0]   r_buttons;

    logic signed [8:0]        dx9, dy9;
    logic [DW-1:0]            dx_ext, dy_ext, sum_x, dif_y;
    logic                     ovf, moved;
    logic [NUM_BUTTONS-1:0]   btn, changed;
    logic [OW-1:0]            ox, oy;

    assign ovf = i_pkt.header[HDR_X_OVF] || i_pkt.header[HDR_Y_OVF];
    assign dx9 = {i_pkt.header[HDR_X_SIGN], i_pkt.x_byte};
    assign dy9 = {i_pkt.header[HDR_Y_SIGN], i_pkt.y_byte};

    // sign-extending casts
    assign dx_ext = DW'(dx9);
    assign dy_ext = DW'(dy9);
    assign sum_x  = DW'(r_pos_x) + dx_ext;
    assign dif_y  = DW'(r_pos_y) - dy_ext;
    assign n_pos_x = sum_x[POSITION_BITS-1:0];
    assign n_pos_y = dif_y[POSITION_BITS-1:0];

    assign btn     = i_pkt.header[HDR_MIDDLE:HDR_LEFT];
    assign changed = btn ^ r_buttons;
    assign moved   = (n_pos_x != r_pos_x) || (n_pos_y != r_pos_y);

    assign ox = OW'(n_pos_x);
    assign oy = OW'(n_pos_y);

    always_comb begin
        o_ev.x      = ox[OUT_POS_W-1:0];
        o_ev.y      = oy[OUT_POS_W-1:0];
        o_ev.kind   = EV_MOVE;
        o_ev.button = BTN_LEFT;
        o_ev_valid  = 1'b0;
        if (i_pkt_valid && !ovf) begin
            // lowest changed button wins
            if (changed[HDR_LEFT]) begin
                o_ev_valid  = 1'b1;
                o_ev.kind   = btn[HDR_LEFT] ? EV_PRESS : EV_RELEASE;
                o_ev.button = BTN_LEFT;
            end else if (changed[HDR_RIGHT]) begin
                o_ev_valid  = 1'b1;
                o_ev.kind   = btn[HDR_RIGHT] ? EV_PRESS : EV_RELEASE;
                o_ev.button = BTN_RIGHT;
            end else if (changed[HDR_MIDDLE]) begin
                o_ev_valid  = 1'b1;
                o_ev.kind   = btn[HDR_MIDDLE] ? EV_PRESS : EV_RELEASE;
                o_ev.button = BTN_MIDDLE;
            end else if (moved) begin
                o_ev_valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= POSITION_BITS'(8);
            r_pos_y   <= POSITION_BITS'(8);
            r_buttons <= '0;
        end else if (i_pkt_valid && !ovf) begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= btn;
        end
    end

endmodule

FILE: src/ps2mpd_event_reg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse event output register
// Holds one event until the receiver takes it.
// ----------------------------------------------------------------------------
module ps2mpd_event_reg
    import ps2mpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_event i_ev,
    input  logic   i_take,
    output logic   o_full,
    output t_event o_ev
);

    logic   r_full;
    t_event r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev <= i_ev;
        end
    end

    assign o_full = r_full;
    assign o_ev   = r_ev;

endmodule

FILE: src/ps2_mouse_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder, top level
// Bytes in, pointer and button events out.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel  (i_rx_valid / o_rx_ready / i_rx_byte): one mouse byte per
//     transfer. Bytes that do not close a packet are always taken, one per
//     cycle. A closing byte is taken whenever the event register is empty
//     or being drained in the same cycle, so the sustained rate is one byte
//     per cycle; the event register is the only thing that can stall rx.
//   evt channel (o_evt_valid / i_evt_ready / event fields): at most one
//     event per packet. The event appears in the cycle after the closing byte
//     transfer and holds until taken.
//   cfg channel (i_cfg_valid / o_cfg_ready / index / data): always ready.
//     Index 0 = enable, index 1 = wheel present; other indexes are dropped.
//     Write only while the block is idle.
//   Reset: packet assembly restarts at the header, pointer goes to (8, 8),
//     buttons read as released, block disabled, no event pending.
//   While disabled, bytes are taken and thrown away.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top
    import ps2mpd_pkg::*;
#(
    parameter int POSITION_BITS = 10
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // event output
    output logic       o_evt_valid,
    input  logic       i_evt_ready,
    output logic [1:0] o_event_kind,
    output logic [1:0] o_button_index,
    output logic [9:0] o_pointer_x,
    output logic [9:0] o_pointer_y,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data
);

    logic    r_enabled;
    logic    r_wheel;

    logic    rx_fire;
    logic    byte_valid;
    logic    completing;
    logic    pkt_valid;
    t_packet pkt;
    logic    ev_valid;
    t_event  ev;
    logic    out_full;
    logic    out_take;
    t_event  out_ev;

    // ---- configuration registers ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_wheel   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLED: r_enabled <= i_cfg_data;
                CFG_WHEEL:   r_wheel   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // ---- input handshake ----
    // Only a packet-closing byte can produce an event, so only that byte
    // waits on the event register.
    assign out_take   = out_full && i_evt_ready;
    assign o_rx_ready = !r_enabled || !completing || !out_full || i_evt_ready;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign byte_valid = rx_fire && r_enabled;

    ps2mpd_assembler u_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wheel      (r_wheel),
        .i_byte_valid (byte_valid),
        .i_byte       (i_rx_byte),
        .o_completing (completing),
        .o_pkt_valid  (pkt_valid),
        .o_pkt        (pkt)
    );

    ps2mpd_decoder #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (pkt_valid),
        .i_pkt       (pkt),
        .o_ev_valid  (ev_valid),
        .o_ev        (ev)
    );

    ps2mpd_event_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ev_valid),
        .i_ev    (ev),
        .i_take  (out_take),
        .o_full  (out_full),
        .o_ev    (out_ev)
    );

    assign o_evt_valid    = out_full;
    assign o_event_kind   = out_ev.kind;
    assign o_button_index = out_ev.button;
    assign o_pointer_x    = out_ev.x;
    assign o_pointer_y    = out_ev.y;

    // ---- checks ----
    // an event is only produced by an accepted byte
    a_ev_from_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_valid |-> (rx_fire && r_enabled && completing))
        else $error("event without closing byte transfer");

    // a new event never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_valid |-> (!out_full || i_evt_ready))
        else $error("pending event overwritten");

    // disabled block leaves the assembler alone
    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |-> !pkt_valid)
        else $error("packet completed while disabled");

    // move events always carry button index zero
    a_move_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_valid && ev.kind == EV_MOVE) |-> (ev.button == BTN_LEFT))
        else $error("move event with nonzero button index");

endmodule
